>>> hw/rtl/sat_pkg.sv
// Package for the section address translator: operation and status codes,
// header magic constants, the section entry type and controller structs.
// No dependencies.
package sat_pkg;

  // Table depth used when the top level is not given another.
  localparam int SAT_SECTIONS_DEF = 16;

  // Field widths of the item and the configuration port.
  localparam int ADDR_W = 32;
  localparam int OP_W   = 2;
  localparam int EIDX_W = 4;
  localparam int CNT_CFG_W = 5;
  localparam int DOS_W  = 16;
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 32;

  // Header values that a valid image carries.
  localparam logic [DOS_W-1:0]  DOS_MAGIC_OK = 16'h5A4D;
  localparam logic [ADDR_W-1:0] NT_SIG_OK    = 32'h0000_4550;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_V2F   = 2'd1;
  localparam logic [OP_W-1:0] OP_F2V   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IW-1:0] CFG_DOS_MAGIC = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_NT_SIG    = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_SECT_CNT  = 2'd2;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_HDR = 2'd1,
    ST_MISS    = 2'd2,
    ST_WRITTEN = 2'd3
  } sat_status_t;

  // One section table entry.
  typedef struct packed {
    logic [ADDR_W-1:0] virt_start;
    logic [ADDR_W-1:0] virt_size;
    logic [ADDR_W-1:0] raw_start;
    logic [ADDR_W-1:0] raw_size;
  } sat_entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        accept;
    logic        issue;
    logic        cmp_en;
    logic        load_out;
    sat_status_t res_code;
  } sat_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hdr_ok;
    logic hit;
    logic out_free;
  } sat_sts_t;

endpackage

>>> hw/rtl/sat_if.sv
// Handshake channel interfaces for the section address translator:
// the input item channel and the result item channel. Depends on sat_pkg.
interface sat_in_if import sat_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [EIDX_W-1:0] entry_index;
  logic [ADDR_W-1:0] virt_start;
  logic [ADDR_W-1:0] virt_size;
  logic [ADDR_W-1:0] raw_start;
  logic [ADDR_W-1:0] raw_size;
  logic [ADDR_W-1:0] query_addr;

  modport source (output valid, op, entry_index, virt_start, virt_size, raw_start,
                  raw_size, query_addr, input ready);
  modport sink (input valid, op, entry_index, virt_start, virt_size, raw_start,
                raw_size, query_addr, output ready);
endinterface

interface sat_out_if import sat_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] mapped_addr;
  logic [1:0]        status;

  modport source (output valid, mapped_addr, status, input ready);
  modport sink (input valid, mapped_addr, status, output ready);
endinterface

>>> hw/rtl/sat_datapath.sv
// Datapath of the section address translator: configuration registers,
// section table memory, range compare, rebase and output register.
// Depends on sat_pkg.
module sat_datapath import sat_pkg::*; #(
  parameter int SECTIONS = SAT_SECTIONS_DEF,
  localparam int AW    = (SECTIONS > 1) ? $clog2(SECTIONS) : 1,
  localparam int CNT_W = $clog2(SECTIONS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  // Configuration port
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata,
  // Input item fields
  input  logic [OP_W-1:0]   in_op,
  input  logic [EIDX_W-1:0] in_entry_index,
  input  logic [ADDR_W-1:0] in_virt_start,
  input  logic [ADDR_W-1:0] in_virt_size,
  input  logic [ADDR_W-1:0] in_raw_start,
  input  logic [ADDR_W-1:0] in_raw_size,
  input  logic [ADDR_W-1:0] in_query_addr,
  // Controller link
  input  sat_cmd_t          cmd,
  input  logic [CNT_W-1:0]  scan_idx,
  output sat_sts_t          sts,
  output logic [CNT_W-1:0]  limit,
  // Result item
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ADDR_W-1:0] out_mapped_addr,
  output logic [1:0]        out_status
);

  localparam int CMP_W = (CNT_W > CNT_CFG_W) ? CNT_W : CNT_CFG_W;

  logic [DOS_W-1:0]     dos_r;
  logic [ADDR_W-1:0]    nt_r;
  logic [CNT_CFG_W-1:0] cnt_r;
  logic [CMP_W-1:0]     cnt_ext;
  logic [CMP_W-1:0]     lim_full;

  sat_entry_t           sect_mem [SECTIONS];
  sat_entry_t           rd_data_r;
  sat_entry_t           wr_entry;
  logic [AW-1:0]        wr_addr;
  logic [AW-1:0]        rd_addr;
  logic                 wr_ok;

  logic [ADDR_W-1:0]    query_r;
  logic                 f2v_r;
  logic [ADDR_W-1:0]    sel_start;
  logic [ADDR_W-1:0]    sel_size;
  logic [ADDR_W-1:0]    sel_other;
  logic [ADDR_W-1:0]    sel_end;
  logic                 hit;
  logic [ADDR_W-1:0]    delta_r;

  logic                 out_valid_r;
  logic [ADDR_W-1:0]    mapped_r;
  logic [1:0]           status_r;

  // Configuration registers; to be written only while idle, not enforced here.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dos_r <= '0;
      nt_r  <= '0;
      cnt_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DOS_MAGIC: dos_r <= cfg_wdata[DOS_W-1:0];
        CFG_NT_SIG:    nt_r  <= cfg_wdata[ADDR_W-1:0];
        CFG_SECT_CNT:  cnt_r <= cfg_wdata[CNT_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // The section count saturates at the table depth.
  assign cnt_ext  = CMP_W'(cnt_r);
  assign lim_full = (cnt_ext > CMP_W'(SECTIONS)) ? CMP_W'(SECTIONS) : cnt_ext;
  assign limit    = CNT_W'(lim_full);

  // Section table: written on a write item, read one entry a cycle during a scan.
  assign wr_entry = '{virt_start: in_virt_start, virt_size: in_virt_size,
                      raw_start: in_raw_start, raw_size: in_raw_size};
  assign wr_addr  = AW'(in_entry_index);
  assign wr_ok    = (32'(in_entry_index) < 32'(SECTIONS));
  assign rd_addr  = AW'(scan_idx);

  always_ff @(posedge clk) begin
    if (cmd.accept && (in_op == OP_WRITE) && wr_ok) begin
      sect_mem[wr_addr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_data_r <= sect_mem[rd_addr];
    end
  end

  // Query address and direction are held for the whole scan.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      query_r <= in_query_addr;
      f2v_r   <= (in_op == OP_F2V);
    end
  end

  // Range check of the entry read last cycle; the end wraps modulo 2^32.
  assign sel_start = f2v_r ? rd_data_r.raw_start  : rd_data_r.virt_start;
  assign sel_size  = f2v_r ? rd_data_r.raw_size   : rd_data_r.virt_size;
  assign sel_other = f2v_r ? rd_data_r.virt_start : rd_data_r.raw_start;
  assign sel_end   = sel_start + sel_size;
  assign hit       = (sel_start <= query_r) && (sel_end > query_r);

  // Offset between the two address spaces of the matching entry.
  always_ff @(posedge clk) begin
    if (cmd.cmp_en && hit) begin
      delta_r <= sel_other - sel_start;
    end
  end

  // Output register; a new result may load as the old one is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      mapped_r <= (cmd.res_code == ST_OK) ? (query_r + delta_r) : '1;
      status_r <= cmd.res_code;
    end
  end

  assign sts.hdr_ok   = (dos_r == DOS_MAGIC_OK) && (nt_r == NT_SIG_OK);
  assign sts.hit      = hit;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_mapped_addr = mapped_r;
  assign out_status      = status_r;

endmodule

>>> hw/rtl/sat_ctrl.sv
// Controller of the section address translator: sequences acceptance,
// the section scan and the loading of the result. Depends on sat_pkg.
module sat_ctrl import sat_pkg::*; #(
  parameter int SECTIONS = SAT_SECTIONS_DEF,
  localparam int CNT_W = $clog2(SECTIONS + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [OP_W-1:0]  in_op,
  input  sat_sts_t         sts,
  input  logic [CNT_W-1:0] limit,
  output sat_cmd_t         cmd,
  output logic [CNT_W-1:0] scan_idx
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             pend_r, pend_nxt;
  sat_status_t      code_r, code_nxt;

  // Next state, scan counter and commands.
  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    pend_nxt     = 1'b0;
    code_nxt     = code_r;
    in_ready     = 1'b0;
    cmd.accept   = 1'b0;
    cmd.issue    = 1'b0;
    cmd.cmp_en   = 1'b0;
    cmd.load_out = 1'b0;
    cmd.res_code = code_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_FIN;
          case (in_op)
            OP_WRITE: code_nxt = ST_WRITTEN;
            OP_V2F, OP_F2V: begin
              if (!sts.hdr_ok) begin
                code_nxt = ST_BAD_HDR;
              end else begin
                idx_nxt   = '0;
                state_nxt = S_SCAN;
              end
            end
            default: code_nxt = ST_MISS;
          endcase
        end
      end
      S_SCAN: begin
        // Entry idx_r-1 is compared while entry idx_r is read.
        cmd.cmp_en = pend_r;
        if (pend_r && sts.hit) begin
          code_nxt  = ST_OK;
          state_nxt = S_FIN;
        end else if (idx_r >= limit) begin
          code_nxt  = ST_MISS;
          state_nxt = S_FIN;
        end else begin
          cmd.issue = 1'b1;
          idx_nxt   = idx_r + CNT_W'(1);
          pend_nxt  = 1'b1;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered controls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      pend_r  <= 1'b0;
      code_r  <= ST_MISS;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      pend_r  <= pend_nxt;
      code_r  <= code_nxt;
    end
  end

  assign scan_idx = idx_r;

  // A read is never issued past the saturated section count.
  a_issue_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> (idx_r < limit))
    else $error("section read issued beyond section count");

  // A compare only follows a read issued the cycle before.
  a_cmp_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cmp_en |-> $past(cmd.issue))
    else $error("compare without a preceding table read");

  // A write item goes straight to the result stage.
  a_write_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && (in_op == OP_WRITE)) |=> (state_r == S_FIN && code_r == ST_WRITTEN))
    else $error("write item did not complete");

  // A translated result is only produced after a hit in the scan.
  a_ok_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && $past(state_r) == S_SCAN && code_r == ST_OK)
      |-> $past(pend_r && sts.hit))
    else $error("translated status without a matching entry");

endmodule

>>> hw/rtl/section_address_translator.sv
// Top level of the section address translator: joins controller and
// datapath to the channels. Depends on sat_pkg, sat_if, sat_ctrl, sat_datapath.
// A new item is accepted only once the previous result is loaded: a write or a rejected
// lookup goes straight to the result; a lookup scans entries 0 to min(section_count,SECTIONS)-1
// in turn, one entry a cycle by the single-port table read, until the first hit.
// The next item is accepted while the previous result waits in the output register.
// Reset: synchronous, active low; clears control and configuration registers; the
// section table is not cleared and holds nothing defined until written.
module section_address_translator import sat_pkg::*; #(
  parameter int SECTIONS = SAT_SECTIONS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata,
  sat_in_if.sink            in_ch,
  sat_out_if.source         out_ch
);

  localparam int CNT_W = $clog2(SECTIONS + 1);

  sat_cmd_t         cmd;
  sat_sts_t         sts;
  logic [CNT_W-1:0] scan_idx;
  logic [CNT_W-1:0] limit;

  // Sequencer.
  sat_ctrl #(.SECTIONS(SECTIONS)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_op    (in_ch.op),
    .sts      (sts),
    .limit    (limit),
    .cmd      (cmd),
    .scan_idx (scan_idx)
  );

  // Table, compare and output register.
  sat_datapath #(.SECTIONS(SECTIONS)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_op           (in_ch.op),
    .in_entry_index  (in_ch.entry_index),
    .in_virt_start   (in_ch.virt_start),
    .in_virt_size    (in_ch.virt_size),
    .in_raw_start    (in_ch.raw_start),
    .in_raw_size     (in_ch.raw_size),
    .in_query_addr   (in_ch.query_addr),
    .cmd             (cmd),
    .scan_idx        (scan_idx),
    .sts             (sts),
    .limit           (limit),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_mapped_addr (out_ch.mapped_addr),
    .out_status      (out_ch.status)
  );

endmodule
